/* rtl/core/mvm_pkg.sv */
`default_nettype none

package mvm_pkg;

  localparam int MAX_ROWS_DEF = 16;
  localparam int MAX_COLS_DEF = 16;

  localparam int CFG_W  = 5;
  localparam int IDX_W  = 4;
  localparam int VAL_W  = 16;
  localparam int PROD_W = 2 * VAL_W;
  localparam int DOT_W  = 40;

  typedef enum logic {
    OP_WEIGHT = 1'b0,
    OP_VECTOR = 1'b1
  } op_t;

  typedef enum logic {
    CFG_ROWS_IN_USE = 1'b0,
    CFG_COLS_IN_USE = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT,
    ST_ERR
  } seq_state_t;

  typedef struct packed {
    op_t                      op;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [VAL_W-1:0]  value;
    logic                     last_element;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]         out_row;
    logic signed [DOT_W-1:0]  dot_value;
    logic                     len_mismatch;
    logic                     last_result;
  } out_item_t;

  // Tag that travels with each operand pair through the MAC pipeline
  typedef struct packed {
    logic issue;
    logic first;
    logic last;
  } mac_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/mvm_wmem.sv */
`default_nettype none

module mvm_wmem
  import mvm_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF,
  localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    wr_en,
  input  wire logic [RIW-1:0]          wr_row,
  input  wire logic [CIW-1:0]          wr_col,
  input  wire logic signed [VAL_W-1:0] wr_data,
  input  wire logic [RIW-1:0]          rd_row,
  input  wire logic [CIW-1:0]          rd_col,
  output logic signed [VAL_W-1:0]      rd_data
);

  logic signed [VAL_W-1:0] mem [MAX_ROWS][MAX_COLS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row][wr_col] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_row][rd_col];
  end

endmodule

`default_nettype wire

/* rtl/core/mvm_mac.sv */
`default_nettype none

module mvm_mac
  import mvm_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire mac_ctrl_t               ctrl,
  input  wire logic signed [VAL_W-1:0] weight,
  input  wire logic signed [VAL_W-1:0] element,
  output logic signed [DOT_W-1:0]      acc,
  output logic                         done
);

  mac_ctrl_t                ctrl_d1_r;
  mac_ctrl_t                ctrl_d2_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [DOT_W-1:0]  acc_r;
  logic signed [DOT_W-1:0]  acc_nxt;
  logic signed [DOT_W-1:0]  prod_ext;
  logic                     done_r;

  // Operands arrive in the cycle after issue, from the registered store reads
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_d1_r <= '0;
      ctrl_d2_r <= '0;
      done_r    <= 1'b0;
    end else begin
      ctrl_d1_r <= ctrl;
      ctrl_d2_r <= ctrl_d1_r;
      done_r    <= ctrl_d2_r.issue & ctrl_d2_r.last;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= weight * element;
  end

  assign prod_ext = {{(DOT_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl_d2_r.issue) begin
      acc_nxt = ctrl_d2_r.first ? prod_ext : acc_r + prod_ext;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

`default_nettype wire

/* rtl/core/matrix_vector_multiply.sv */
`default_nettype none

// Matrix-vector multiply over signed Q4.12 data with one shared multiply-accumulate
// unit. A weight request or a non-final vector element is taken without leaving the
// idle state. The vector element marked last starts the multiply: for each row, one
// operand pair per cycle goes through the single MAC, then the store read, multiply
// and accumulate registers drain and the result register is loaded. The input stays
// not ready until every row has been loaded, longer if the result side stalls. A
// length mismatch gives one error result. Results wait in an output register, so
// the input side is open again as soon as the last row has been loaded there.
module matrix_vector_multiply
  import mvm_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_data,
  input  wire logic             cfg_we,
  input  wire cfg_index_t       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int CCW = $clog2(MAX_COLS + 1);
  localparam int ECW = $clog2(MAX_COLS + 2);

  seq_state_t              state_r, state_nxt;
  logic [RIW-1:0]          row_r, row_nxt;
  logic [CIW-1:0]          col_r, col_nxt;
  logic [ECW-1:0]          elem_cnt_r, elem_cnt_nxt;
  logic [ECW-1:0]          elem_cnt_inc;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_r, out_nxt;
  logic [CFG_W-1:0]        rows_cfg_r;
  logic [CFG_W-1:0]        cols_cfg_r;
  logic [RCW-1:0]          rows_eff;
  logic [CCW-1:0]          cols_eff;

  logic                    out_free;
  logic                    col_last;
  logic                    row_last;
  logic                    wr_en;
  logic                    vec_we;
  mac_ctrl_t               mac_ctrl;
  logic signed [VAL_W-1:0] weight_rd;
  logic signed [VAL_W-1:0] vec_rd_r;
  logic signed [VAL_W-1:0] vec_mem [MAX_COLS];
  logic signed [DOT_W-1:0] mac_acc;
  logic                    mac_done;

  // Zero counts as one, anything above the maximum as the maximum
  always_comb begin
    if (rows_cfg_r == '0) begin
      rows_eff = RCW'(1);
    end else if (32'(rows_cfg_r) > MAX_ROWS) begin
      rows_eff = RCW'(MAX_ROWS);
    end else begin
      rows_eff = RCW'(rows_cfg_r);
    end
    if (cols_cfg_r == '0) begin
      cols_eff = CCW'(1);
    end else if (32'(cols_cfg_r) > MAX_COLS) begin
      cols_eff = CCW'(MAX_COLS);
    end else begin
      cols_eff = CCW'(cols_cfg_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= CFG_W'(16);
      cols_cfg_r <= CFG_W'(16);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROWS_IN_USE: rows_cfg_r <= cfg_wdata;
        CFG_COLS_IN_USE: cols_cfg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_ready     = (state_r == ST_IDLE);
  assign out_free     = !out_valid_r || out_ready;
  assign col_last     = (32'(col_r) + 32'd1) == 32'(cols_eff);
  assign row_last     = (32'(row_r) + 32'd1) == 32'(rows_eff);
  assign elem_cnt_inc = (32'(elem_cnt_r) < MAX_COLS + 1) ? elem_cnt_r + ECW'(1) : elem_cnt_r;

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    elem_cnt_nxt  = elem_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    wr_en         = 1'b0;
    vec_we        = 1'b0;
    mac_ctrl      = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.op == OP_WEIGHT) begin
            wr_en = (32'(in_data.row_index) < MAX_ROWS) &&
                    (32'(in_data.col_index) < MAX_COLS);
          end else begin
            vec_we       = 32'(elem_cnt_r) < MAX_COLS;
            elem_cnt_nxt = elem_cnt_inc;
            if (in_data.last_element) begin
              elem_cnt_nxt = '0;
              row_nxt      = '0;
              col_nxt      = '0;
              state_nxt    = (32'(elem_cnt_inc) != 32'(cols_eff)) ? ST_ERR : ST_RUN;
            end
          end
        end
      end

      ST_RUN: begin
        mac_ctrl.issue = 1'b1;
        mac_ctrl.first = (col_r == '0);
        mac_ctrl.last  = col_last;
        if (col_last) begin
          col_nxt   = '0;
          state_nxt = ST_DRAIN;
        end else begin
          col_nxt = col_r + CIW'(1);
        end
      end

      ST_DRAIN: begin
        if (mac_done) begin
          state_nxt = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_nxt.out_row      = IDX_W'(row_r);
          out_nxt.dot_value    = mac_acc;
          out_nxt.len_mismatch = 1'b0;
          out_nxt.last_result  = row_last;
          if (row_last) begin
            row_nxt   = '0;
            state_nxt = ST_IDLE;
          end else begin
            row_nxt   = row_r + RIW'(1);
            state_nxt = ST_RUN;
          end
        end
      end

      ST_ERR: begin
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_nxt.out_row      = '0;
          out_nxt.dot_value    = '0;
          out_nxt.len_mismatch = 1'b1;
          out_nxt.last_result  = 1'b1;
          state_nxt            = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_r       <= '0;
      col_r       <= '0;
      elem_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      elem_cnt_r  <= elem_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  // Vector store: written in arrival order, read alongside the weight store
  always_ff @(posedge clk) begin
    if (vec_we) begin
      vec_mem[elem_cnt_r[CIW-1:0]] <= in_data.value;
    end
    vec_rd_r <= vec_mem[col_r];
  end

  mvm_wmem #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_wmem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_row  (RIW'(in_data.row_index)),
    .wr_col  (CIW'(in_data.col_index)),
    .wr_data (in_data.value),
    .rd_row  (row_r),
    .rd_col  (col_r),
    .rd_data (weight_rd)
  );

  mvm_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (mac_ctrl),
    .weight  (weight_rd),
    .element (vec_rd_r),
    .acc     (mac_acc),
    .done    (mac_done)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> (state_r == ST_DRAIN))
    else $error("MAC completion outside drain state");

  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.len_mismatch) |-> (out_r.last_result && out_r.dot_value == '0))
    else $error("error result carries data or lacks last mark");

  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.op == OP_VECTOR && in_data.last_element) |=> !in_ready)
    else $error("input still open after final vector element");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(elem_cnt_r) <= MAX_COLS + 1)
    else $error("element count beyond saturation");
`endif

endmodule

`default_nettype wire
